// File: design/lidar_point_frustum_clip_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lidar point frustum clip unit
// Shared implication forms, clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef LIDAR_POINT_FRUSTUM_CLIP_UNIT_MACROS_SVH
`define LIDAR_POINT_FRUSTUM_CLIP_UNIT_MACROS_SVH

// Same-cycle implication
`define LPFC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LPFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/lpfc_pkg.sv
// ----------------------------------------------------------------------------
// lpfc_pkg
// Types, widths and register codes shared by the frustum clip unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpfc_pkg;

  // Field and datapath widths
  localparam int unsigned COEF_W    = 32;
  localparam int unsigned PT_W      = 32;
  localparam int unsigned IDX_W     = 17;
  localparam int unsigned PROD_W    = 64;
  localparam int unsigned ACC_W     = 50;
  localparam int unsigned BND_W     = 32;
  localparam int unsigned PW_LO_W   = 25;
  localparam int unsigned PW_HI_W   = ACC_W - PW_LO_W;
  localparam int unsigned Q_SHIFT   = 16;
  localparam int unsigned PIX_SHIFT = 17;
  localparam int unsigned ROWS      = 3;
  localparam int unsigned COEFS     = 4;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 3;

  // Default parameter values
  localparam int unsigned IMAGE_WIDTH_PX_DEF   = 1242;
  localparam int unsigned IMAGE_HEIGHT_PX_DEF  = 375;
  localparam int unsigned MAX_CLOUD_POINTS_DEF = 131072;

  // Reset of the forward distance threshold (5.0 m)
  localparam logic signed [PT_W-1:0] FWD_RESET = 32'sd327680;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_M0AB = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_M0CD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_M1AB = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_M1CD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_M2AB = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_M2CD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BOX  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FWD  = 3'd7;

  typedef logic [COEF_W-1:0] coef_t;
  typedef coef_t [ROWS-1:0][COEFS-1:0] matrix_t;

  // Input transaction
  typedef struct packed {
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic signed [PT_W-1:0] point_z;
    logic                   first_of_cloud;
  } lpfc_in_t;

  // Output transaction
  typedef struct packed {
    logic             keep;
    logic [IDX_W-1:0] point_index;
    logic             behind_camera;
  } lpfc_out_t;

  // Box bounds in units of 2^-17 pixel
  typedef struct packed {
    logic signed [BND_W-1:0] lu;
    logic signed [BND_W-1:0] ru;
    logic signed [BND_W-1:0] lv;
    logic signed [BND_W-1:0] rv;
  } bounds_t;

  // Projected point between the projection and box test stages
  typedef struct packed {
    logic signed [ACC_W-1:0] pu;
    logic signed [ACC_W-1:0] pv;
    logic signed [ACC_W-1:0] pw;
    logic                    far;
    logic [IDX_W-1:0]        point_index;
  } proj_t;

endpackage

// File: design/lpfc_cfg_regs.sv
// ----------------------------------------------------------------------------
// lpfc_cfg_regs
// Configuration registers and the derived pixel bounds of the detection box.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpfc_cfg_regs #(
  parameter int unsigned IMAGE_WIDTH_PX  = lpfc_pkg::IMAGE_WIDTH_PX_DEF,
  parameter int unsigned IMAGE_HEIGHT_PX = lpfc_pkg::IMAGE_HEIGHT_PX_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lpfc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lpfc_pkg::CFG_W-1:0]          cfg_wdata_i,
  output lpfc_pkg::matrix_t                   matrix_o,
  output logic signed [lpfc_pkg::PT_W-1:0]    min_fwd_o,
  output lpfc_pkg::bounds_t                   bounds_o
);

  localparam int unsigned HALF_W = lpfc_pkg::CFG_W / 2;
  localparam int unsigned EDGE_W = 19;
  localparam int unsigned PX_W   = 15;
  localparam logic signed [PX_W-1:0] PX_U = PX_W'(IMAGE_WIDTH_PX);
  localparam logic signed [PX_W-1:0] PX_V = PX_W'(IMAGE_HEIGHT_PX);

  logic [lpfc_pkg::CFG_W-1:0]       mat_q [2*lpfc_pkg::ROWS];
  logic [lpfc_pkg::CFG_W-1:0]       box_q;
  logic signed [lpfc_pkg::PT_W-1:0] fwd_q;
  lpfc_pkg::bounds_t                bounds_q, bounds_d;

  logic signed [EDGE_W-1:0] lo_u, hi_u, lo_v, hi_v;
  logic signed [EDGE_W+PX_W-1:0] lu_full, ru_full, lv_full, rv_full;

  // Take register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2*lpfc_pkg::ROWS; i++) begin
        mat_q[i] <= '0;
      end
      box_q <= '0;
      fwd_q <= lpfc_pkg::FWD_RESET;
    end else if (cfg_we_i) begin
      priority if (cfg_index_i == lpfc_pkg::REG_BOX) begin
        box_q <= cfg_wdata_i;
      end else if (cfg_index_i == lpfc_pkg::REG_FWD) begin
        fwd_q <= $signed(cfg_wdata_i[lpfc_pkg::PT_W-1:0]);
      end else begin
        mat_q[cfg_index_i] <= cfg_wdata_i;
      end
    end
  end

  // Unpack coefficients: even coefficient in the low word
  always_comb begin
    for (int r = 0; r < lpfc_pkg::ROWS; r++) begin
      for (int k = 0; k < lpfc_pkg::COEFS; k++) begin
        matrix_o[r][k] = mat_q[r*2 + k/2][(k%2)*HALF_W +: HALF_W];
      end
    end
  end

  // Box edges doubled: 2*centre -/+ size
  always_comb begin
    lo_u = $signed({2'b00, box_q[15:0], 1'b0}) - $signed({3'b000, box_q[47:32]});
    hi_u = $signed({2'b00, box_q[15:0], 1'b0}) + $signed({3'b000, box_q[47:32]});
    lo_v = $signed({2'b00, box_q[31:16], 1'b0}) - $signed({3'b000, box_q[63:48]});
    hi_v = $signed({2'b00, box_q[31:16], 1'b0}) + $signed({3'b000, box_q[63:48]});
    lu_full = lo_u * PX_U;
    ru_full = hi_u * PX_U;
    lv_full = lo_v * PX_V;
    rv_full = hi_v * PX_V;
    bounds_d.lu = lu_full[lpfc_pkg::BND_W-1:0];
    bounds_d.ru = ru_full[lpfc_pkg::BND_W-1:0];
    bounds_d.lv = lv_full[lpfc_pkg::BND_W-1:0];
    bounds_d.rv = rv_full[lpfc_pkg::BND_W-1:0];
  end

  // Register scaled bounds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds_q <= '0;
    end else begin
      bounds_q <= bounds_d;
    end
  end

  assign min_fwd_o = fwd_q;
  assign bounds_o  = bounds_q;

endmodule

// File: design/lpfc_project.sv
// ----------------------------------------------------------------------------
// lpfc_project
// Two-stage projection: nine coefficient products, then floor and sum per row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpfc_project (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  lpfc_pkg::lpfc_in_t                in_data_i,
  input  logic [lpfc_pkg::IDX_W-1:0]        in_index_i,
  input  lpfc_pkg::matrix_t                 matrix_i,
  input  logic signed [lpfc_pkg::PT_W-1:0]  min_fwd_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output lpfc_pkg::proj_t                   out_data_o
);

  localparam int unsigned NPT = 3;

  logic                                 s1_valid_q, s2_valid_q;
  logic                                 s1_ready, s2_ready;
  logic signed [lpfc_pkg::PROD_W-1:0]   prod_q [lpfc_pkg::ROWS][NPT];
  logic signed [lpfc_pkg::PROD_W-1:0]   prod_d [lpfc_pkg::ROWS][NPT];
  logic signed [lpfc_pkg::PT_W-1:0]     pt     [NPT];
  logic                                 far_q;
  logic [lpfc_pkg::IDX_W-1:0]           idx_q;
  logic signed [lpfc_pkg::PROD_W-1:0]   sum    [lpfc_pkg::ROWS];
  lpfc_pkg::proj_t                      s2_q, s2_d;

  // Stall chain
  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  // Stage 1: products of coefficients and coordinates
  always_comb begin
    pt[0] = in_data_i.point_x;
    pt[1] = in_data_i.point_y;
    pt[2] = in_data_i.point_z;
    for (int r = 0; r < lpfc_pkg::ROWS; r++) begin
      for (int k = 0; k < NPT; k++) begin
        prod_d[r][k] = $signed(matrix_i[r][k]) * pt[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      prod_q <= prod_d;
      far_q  <= in_data_i.point_x > min_fwd_i;
      idx_q  <= in_index_i;
    end
  end

  // Stage 2: floor each product to Q16 and add the offset column
  always_comb begin
    for (int r = 0; r < lpfc_pkg::ROWS; r++) begin
      sum[r] = lpfc_pkg::PROD_W'($signed(matrix_i[r][3]))
             + (prod_q[r][0] >>> lpfc_pkg::Q_SHIFT)
             + (prod_q[r][1] >>> lpfc_pkg::Q_SHIFT)
             + (prod_q[r][2] >>> lpfc_pkg::Q_SHIFT);
    end
    s2_d.pu          = sum[0][lpfc_pkg::ACC_W-1:0];
    s2_d.pv          = sum[1][lpfc_pkg::ACC_W-1:0];
    s2_d.pw          = sum[2][lpfc_pkg::ACC_W-1:0];
    s2_d.far         = far_q;
    s2_d.point_index = idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_q;

endmodule

// File: design/lpfc_box_test.sv
// ----------------------------------------------------------------------------
// lpfc_box_test
// Two-stage exact box test: split bound-by-depth products, then combine and
// compare against the scaled image coordinates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpfc_box_test (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lpfc_pkg::proj_t      in_data_i,
  input  lpfc_pkg::bounds_t    bounds_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lpfc_pkg::lpfc_out_t  out_data_o
);

  localparam int unsigned NB    = 4;
  localparam int unsigned LO_W  = lpfc_pkg::BND_W + lpfc_pkg::PW_LO_W + 1;
  localparam int unsigned HI_W  = lpfc_pkg::BND_W + lpfc_pkg::PW_HI_W;
  localparam int unsigned CMP_W = lpfc_pkg::BND_W + lpfc_pkg::ACC_W;

  logic                                s3_valid_q, s4_valid_q;
  logic                                s3_ready, s4_ready;
  logic signed [lpfc_pkg::BND_W-1:0]   bnd [NB];
  logic signed [lpfc_pkg::PW_LO_W:0]   pw_lo;
  logic signed [lpfc_pkg::PW_HI_W-1:0] pw_hi;
  logic signed [LO_W-1:0]              pp_lo_q [NB], pp_lo_d [NB];
  logic signed [HI_W-1:0]              pp_hi_q [NB], pp_hi_d [NB];
  logic signed [lpfc_pkg::ACC_W-1:0]   pu_q, pv_q;
  logic                                pos_q, far_q;
  logic [lpfc_pkg::IDX_W-1:0]          idx_q;
  logic signed [CMP_W-1:0]             bw [NB];
  logic signed [CMP_W-1:0]             su, sv;
  logic                                in_u, in_v;
  lpfc_pkg::lpfc_out_t                 s4_q, s4_d;

  // Stall chain
  assign s4_ready   = !s4_valid_q || out_ready_i;
  assign s3_ready   = !s3_valid_q || s4_ready;
  assign in_ready_o = s3_ready;

  // Stage 3: bound times depth as two partial products
  always_comb begin
    bnd[0] = bounds_i.lu;
    bnd[1] = bounds_i.ru;
    bnd[2] = bounds_i.lv;
    bnd[3] = bounds_i.rv;
    pw_lo  = $signed({1'b0, in_data_i.pw[lpfc_pkg::PW_LO_W-1:0]});
    pw_hi  = $signed(in_data_i.pw[lpfc_pkg::ACC_W-1:lpfc_pkg::PW_LO_W]);
    for (int i = 0; i < NB; i++) begin
      pp_lo_d[i] = bnd[i] * pw_lo;
      pp_hi_d[i] = bnd[i] * pw_hi;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && in_valid_i) begin
      pp_lo_q <= pp_lo_d;
      pp_hi_q <= pp_hi_d;
      pu_q    <= in_data_i.pu;
      pv_q    <= in_data_i.pv;
      pos_q   <= !in_data_i.pw[lpfc_pkg::ACC_W-1] && (in_data_i.pw != '0);
      far_q   <= in_data_i.far;
      idx_q   <= in_data_i.point_index;
    end
  end

  // Stage 4: rebuild full products and compare, edges included
  always_comb begin
    for (int i = 0; i < NB; i++) begin
      bw[i] = (CMP_W'(pp_hi_q[i]) <<< lpfc_pkg::PW_LO_W) + CMP_W'(pp_lo_q[i]);
    end
    su   = CMP_W'(pu_q) <<< lpfc_pkg::PIX_SHIFT;
    sv   = CMP_W'(pv_q) <<< lpfc_pkg::PIX_SHIFT;
    in_u = (bw[0] <= su) && (su <= bw[1]);
    in_v = (bw[2] <= sv) && (sv <= bw[3]);
    s4_d.keep          = far_q && pos_q && in_u && in_v;
    s4_d.point_index   = idx_q;
    s4_d.behind_camera = far_q && !pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (s4_ready) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_ready && s3_valid_q) begin
      s4_q <= s4_d;
    end
  end

  assign out_valid_o = s4_valid_q;
  assign out_data_o  = s4_q;

endmodule

// File: design/lidar_point_frustum_clip_unit.sv
// Lidar point frustum clip unit: takes one lidar point per clock while the
// output is not stalled and returns one result per point, in order. A point
// passes four register stages: the nine 32x32 coefficient products, the
// per-row floor and sum, the split products of box bounds by depth, and the
// final wide compare, which is also the output register. Throughput is one
// point per cycle; a stall on the output backs up stage by stage and nothing
// is dropped or repeated. Configuration writes take effect at once, except the
// box bounds, which are rescaled to pixels in a register behind the box register;
// write registers only while no points are in flight.
// ----------------------------------------------------------------------------
// lidar_point_frustum_clip_unit
// Projects lidar points with a 3x4 matrix and tests them against a 2-D box.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "lidar_point_frustum_clip_unit_macros.svh"

module lidar_point_frustum_clip_unit #(
  parameter int unsigned IMAGE_WIDTH_PX   = lpfc_pkg::IMAGE_WIDTH_PX_DEF,
  parameter int unsigned IMAGE_HEIGHT_PX  = lpfc_pkg::IMAGE_HEIGHT_PX_DEF,
  parameter int unsigned MAX_CLOUD_POINTS = lpfc_pkg::MAX_CLOUD_POINTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  lpfc_pkg::lpfc_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output lpfc_pkg::lpfc_out_t             out_data_o,
  input  logic                            cfg_we_i,
  input  logic [lpfc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lpfc_pkg::CFG_W-1:0]      cfg_wdata_i
);

  localparam int unsigned CNT_W = $clog2(MAX_CLOUD_POINTS);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CLOUD_POINTS - 1);

  logic                               in_fire;
  logic [CNT_W-1:0]                   cnt_q, cnt_d, cnt_base;
  logic [lpfc_pkg::IDX_W-1:0]         point_idx;
  lpfc_pkg::matrix_t                  matrix;
  logic signed [lpfc_pkg::PT_W-1:0]   min_fwd;
  lpfc_pkg::bounds_t                  bounds;
  logic                               proj_valid, proj_ready;
  lpfc_pkg::proj_t                    proj_data;

  assign in_fire = in_valid_i && in_ready_o;

  // Point counter: restart on a new cloud, saturate at the cloud limit
  always_comb begin
    cnt_base  = in_data_i.first_of_cloud ? '0 : cnt_q;
    cnt_d     = (cnt_base < CNT_MAX) ? cnt_base + CNT_W'(1) : cnt_base;
    point_idx = lpfc_pkg::IDX_W'({{lpfc_pkg::IDX_W{1'b0}}, cnt_base});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_fire) begin
      cnt_q <= cnt_d;
    end
  end

  lpfc_cfg_regs #(
    .IMAGE_WIDTH_PX  (IMAGE_WIDTH_PX),
    .IMAGE_HEIGHT_PX (IMAGE_HEIGHT_PX)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .matrix_o    (matrix),
    .min_fwd_o   (min_fwd),
    .bounds_o    (bounds)
  );

  lpfc_project u_project (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .in_index_i  (point_idx),
    .matrix_i    (matrix),
    .min_fwd_i   (min_fwd),
    .out_valid_o (proj_valid),
    .out_ready_i (proj_ready),
    .out_data_o  (proj_data)
  );

  lpfc_box_test u_box (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (proj_valid),
    .in_ready_o  (proj_ready),
    .in_data_i   (proj_data),
    .bounds_i    (bounds),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // A kept point is never flagged as behind the camera
  `LPFC_ASSERT_NOW(a_keep_not_behind, clk_i, rst_ni, out_valid_o, !(out_data_o.keep && out_data_o.behind_camera), "keep and behind_camera both set")

  // Input back-pressure only when every stage is full and the output stalls
  `LPFC_ASSERT_NOW(a_stall_source, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i, "input stalled without output back-pressure")

  // A point that starts a cloud leaves the counter at one
  `LPFC_ASSERT_NEXT(a_cloud_restart, clk_i, rst_ni, in_fire && in_data_i.first_of_cloud, cnt_q == CNT_W'(1), "point counter not restarted")

endmodule

// File: verif/tb_lidar_point_frustum_clip_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lidar_point_frustum_clip_unit
// Self-checking bench for the lidar point frustum clip unit. Points are
// driven over valid/ready with random gaps. Each accepted point is projected
// and tested against the box by a bit-exact model kept in the bench. Every
// output transaction is compared field by field with the oldest prediction.
// The register setups cover camera-like, random and extreme matrices, boxes
// and thresholds. A closing cloud runs back to back.
// ----------------------------------------------------------------------------

module tb_lidar_point_frustum_clip_unit;

  localparam int ONE_M = 65536;

  // Clock, reset and block ports, all known from time zero
  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_ready_o;
  lpfc_pkg::lpfc_in_t             in_data_i   = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  lpfc_pkg::lpfc_out_t            out_data_o;
  logic                           cfg_we_i    = 1'b0;
  logic [lpfc_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [lpfc_pkg::CFG_W-1:0]     cfg_wdata_i = '0;

  // Points waiting to be offered and results waiting to arrive
  lpfc_pkg::lpfc_in_t  point_queue[$];
  lpfc_pkg::lpfc_out_t expected_results[$];

  // Register copies and point counter of the bench model
  logic [63:0]        mirror_matrix [6];
  logic [63:0]        mirror_box;
  logic signed [31:0] mirror_min_fwd;
  int unsigned        cloud_count;

  // Setup staged for the next register load
  logic [63:0] setup_m [6];
  logic [63:0] setup_box;

  logic [31:0] corner_vals [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};

  int idle_mode;
  int mismatch_count;
  int results_checked;
  int send_gap;
  int recv_stall;
  int recv_hold;

  lidar_point_frustum_clip_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Append a point to the pending queue
  function automatic void enqueue_point(lpfc_pkg::lpfc_in_t pt);
    point_queue = {point_queue, pt};
  endfunction

  // Append a prediction to the expected results
  function automatic void enqueue_result(lpfc_pkg::lpfc_out_t res);
    expected_results = {expected_results, res};
  endfunction

  // Wait before the next transaction, shaped by the current idle mode
  function automatic int draw_wait();
    case (idle_mode)
      0:       return 0;
      1:       return $urandom_range(0, 18);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
    endcase
  endfunction

  function automatic logic signed [31:0] coef_at(int r, int k);
    logic [63:0] w;
    w = mirror_matrix[r * 2 + k / 2];
    return (k % 2) ? w[63:32] : w[31:0];
  endfunction

  // One projected component: floored Q16 products plus the offset term
  function automatic logic signed [63:0] project_row(int r, lpfc_pkg::lpfc_in_t pt);
    logic signed [31:0] pcoord [3];
    logic signed [63:0] acc;
    logic signed [63:0] prod;
    pcoord[0] = pt.point_x;
    pcoord[1] = pt.point_y;
    pcoord[2] = pt.point_z;
    acc = coef_at(r, 3);
    for (int k = 0; k < 3; k++) begin
      prod = coef_at(r, k) * pcoord[k];
      acc += prod >>> 16;
    end
    return acc;
  endfunction

  // Exact edge-inclusive span test, bounds in units of 2^-17 pixel
  function automatic bit in_span(logic signed [63:0] pc, logic signed [63:0] pw,
                                 logic [15:0] centre, logic [15:0] size, longint px);
    longint lo_b;
    longint hi_b;
    logic signed [127:0] w_lo, w_hi, w_pc, w_pw;
    lo_b = (2 * longint'(centre) - longint'(size)) * px;
    hi_b = (2 * longint'(centre) + longint'(size)) * px;
    w_lo = lo_b;
    w_hi = hi_b;
    w_pw = pw;
    w_pc = pc;
    w_pc = w_pc <<< 17;
    return (w_lo * w_pw <= w_pc) && (w_pc <= w_hi * w_pw);
  endfunction

  // Expected result of one point; advances the point counter
  function automatic lpfc_pkg::lpfc_out_t predict_clip(lpfc_pkg::lpfc_in_t pt);
    lpfc_pkg::lpfc_out_t res;
    logic signed [63:0] pu, pv, pw;
    if (pt.first_of_cloud) cloud_count = 0;
    res.point_index   = cloud_count[lpfc_pkg::IDX_W-1:0];
    res.keep          = 1'b0;
    res.behind_camera = 1'b0;
    if (cloud_count < lpfc_pkg::MAX_CLOUD_POINTS_DEF - 1) cloud_count++;
    if ($signed(pt.point_x) > mirror_min_fwd) begin
      pu = project_row(0, pt);
      pv = project_row(1, pt);
      pw = project_row(2, pt);
      if (pw <= 0) begin
        res.behind_camera = 1'b1;
      end else begin
        res.keep = in_span(pu, pw, mirror_box[15:0], mirror_box[47:32],
                           lpfc_pkg::IMAGE_WIDTH_PX_DEF) &&
                   in_span(pv, pw, mirror_box[31:16], mirror_box[63:48],
                           lpfc_pkg::IMAGE_HEIGHT_PX_DEF);
      end
    end
    return res;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // Input driver: offer queued points, hold each until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        enqueue_result(predict_clip(in_data_i));
        send_gap = draw_wait();
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (point_queue.size() > 0) begin
          in_data_i  <= point_queue.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check each transaction, stall at random, hold off twice
  always @(posedge clk_i or negedge rst_ni) begin
    lpfc_pkg::lpfc_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall = 0;
      recv_hold  = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("result with nothing expected, index", out_data_o.point_index, -1);
        end else begin
          want = expected_results.pop_front();
          if (out_data_o.keep !== want.keep)
            flag_mismatch("keep", out_data_o.keep, want.keep);
          if (out_data_o.point_index !== want.point_index)
            flag_mismatch("point_index", out_data_o.point_index, want.point_index);
          if (out_data_o.behind_camera !== want.behind_camera)
            flag_mismatch("behind_camera", out_data_o.behind_camera, want.behind_camera);
        end
        results_checked++;
        recv_stall = draw_wait();
        // Long hold-off so the pipeline fills and back-pressures the input
        if (results_checked == 300 || results_checked == 900) recv_hold = 240;
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_ready_i <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [lpfc_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    if (idx == lpfc_pkg::REG_BOX)      mirror_box = val;
    else if (idx == lpfc_pkg::REG_FWD) mirror_min_fwd = val[31:0];
    else                               mirror_matrix[idx] = val;
  endtask

  // Write every register from the staged setup, then let the box settle
  task automatic load_setup(logic [31:0] fwd);
    for (int i = 0; i < 6; i++)
      write_reg(lpfc_pkg::REG_M0AB + lpfc_pkg::CFG_IDX_W'(i), setup_m[i]);
    write_reg(lpfc_pkg::REG_BOX, setup_box);
    write_reg(lpfc_pkg::REG_FWD, {32'h0, fwd});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    repeat (2) @(posedge clk_i);
  endtask

  // Wait until no point is pending or in flight, then past the pipeline depth;
  // sample between edges so the driver's updates have settled
  task automatic drain();
    while (point_queue.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Pinhole camera looking along lidar x; depth row given separately
  function automatic void stage_camera(int f, int cx_q, int cy_q,
                                       logic [31:0] w0, logic [31:0] w3);
    setup_m[0] = {32'(-f * ONE_M), 32'(cx_q)};
    setup_m[1] = 64'h0;
    setup_m[2] = {32'h0, 32'(cy_q)};
    setup_m[3] = {32'h0, 32'(-f * ONE_M)};
    setup_m[4] = {32'h0, w0};
    setup_m[5] = {w3, 32'h0};
  endfunction

  function automatic lpfc_pkg::lpfc_in_t pt_of(logic [31:0] x, logic [31:0] y,
                                               logic [31:0] z, bit first);
    lpfc_pkg::lpfc_in_t pt;
    pt.point_x        = x;
    pt.point_y        = y;
    pt.point_z        = z;
    pt.first_of_cloud = first;
    return pt;
  endfunction

  // Mostly points in front of the sensor, some full-range noise and corners
  function automatic lpfc_pkg::lpfc_in_t make_point(bit may_restart);
    lpfc_pkg::lpfc_in_t pt;
    int sel;
    int x;
    int span_y;
    int span_z;
    sel = $urandom_range(0, 99);
    if (sel < 75) begin
      x      = $urandom_range(4 * ONE_M, 80 * ONE_M);
      span_y = x / 10 * 9;
      span_z = x / 10 * 4;
      pt.point_x = x;
      pt.point_y = int'($urandom_range(0, 2 * span_y)) - span_y;
      pt.point_z = int'($urandom_range(0, 2 * span_z)) - span_z;
    end else if (sel < 92) begin
      pt.point_x = $urandom;
      pt.point_y = $urandom;
      pt.point_z = $urandom;
    end else begin
      pt.point_x = corner_vals[$urandom_range(0, 3)];
      pt.point_y = corner_vals[$urandom_range(0, 3)];
      pt.point_z = corner_vals[$urandom_range(0, 3)];
    end
    pt.first_of_cloud = may_restart && ($urandom_range(0, 63) == 0);
    return pt;
  endfunction

  function automatic logic [63:0] typical_box();
    return {16'($urandom_range(3000, 30000)), 16'($urandom_range(3000, 30000)),
            16'($urandom_range(20000, 45000)), 16'($urandom_range(20000, 45000))};
  endfunction

  task automatic run_phase(int n_items, int mode, bit may_restart);
    idle_mode = mode;
    for (int i = 0; i < n_items; i++) enqueue_point(make_point(may_restart));
    drain();
  endtask

  // Run limit, far above the slowest correct run
  initial begin
    #12_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Stimulus sequence
  initial begin
    logic [31:0] fwd;
    for (int i = 0; i < 6; i++) mirror_matrix[i] = 64'h0;
    mirror_box      = 64'h0;
    mirror_min_fwd  = lpfc_pkg::FWD_RESET;
    cloud_count     = 0;
    mismatch_count  = 0;
    results_checked = 0;
    idle_mode       = 2;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset setup: zero matrix gives zero depth; threshold rejects near points
    enqueue_point(pt_of(10 * ONE_M, 0, 0, 1'b1));
    enqueue_point(pt_of(5 * ONE_M, ONE_M, ONE_M, 1'b0));
    enqueue_point(pt_of(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
    enqueue_point(pt_of(32'h7FFF_FFFF, 0, 0, 1'b0));
    drain();

    // Camera setup with a central box; edge of threshold and field extremes
    stage_camera(700, 621 * ONE_M, 12288000, ONE_M, 32'h0);
    setup_box = {16'd19661, 16'd19661, 16'd32768, 16'd32768};
    load_setup(lpfc_pkg::FWD_RESET);
    idle_mode = 1;
    enqueue_point(pt_of(10 * ONE_M, 0, 0, 1'b1));
    enqueue_point(pt_of(5 * ONE_M + 1, 0, 0, 1'b0));
    enqueue_point(pt_of(5 * ONE_M, 0, 0, 1'b0));
    enqueue_point(pt_of(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
    enqueue_point(pt_of(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
    enqueue_point(pt_of(20 * ONE_M, 20 * ONE_M, 0, 1'b0));
    enqueue_point(pt_of(20 * ONE_M, -3 * ONE_M, ONE_M, 1'b0));
    enqueue_point(pt_of(32'hFFFF_FFFF, 0, 0, 1'b0));
    enqueue_point(pt_of(15 * ONE_M, ONE_M, -ONE_M, 1'b1));
    enqueue_point(pt_of(30 * ONE_M, -8 * ONE_M, -5 * ONE_M, 1'b0));
    drain();

    // Zero-size box on the principal point: only an exact hit on the edge passes
    setup_box = {16'd0, 16'd0, 16'd32768, 16'd32768};
    load_setup(32'h8000_0000);
    idle_mode = 0;
    enqueue_point(pt_of(10 * ONE_M, 0, 0, 1'b0));
    enqueue_point(pt_of(10 * ONE_M, 1, 0, 1'b0));
    enqueue_point(pt_of(10 * ONE_M, 0, 32'hFFFF_FFFF, 1'b0));
    enqueue_point(pt_of(-10 * ONE_M, 0, 0, 1'b0));
    enqueue_point(pt_of(0, 0, 0, 1'b0));
    enqueue_point(pt_of(32'h8000_0000, 0, 0, 1'b0));
    drain();

    // Random phases, one register setup each
    for (int ph = 0; ph < 8; ph++) begin
      stage_camera($urandom_range(300, 1200), $urandom_range(0, 1242) * ONE_M,
                   $urandom_range(0, 375) * ONE_M, ONE_M, 32'h0);
      setup_box = typical_box();
      fwd = lpfc_pkg::FWD_RESET;
      case (ph)
        1: begin
          // box hanging over the top-left image corner
          setup_box = {16'($urandom_range(40000, 65535)), 16'($urandom_range(40000, 65535)),
                       16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000))};
          fwd = 32'h8000_0000;
        end
        2: begin
          for (int i = 0; i < 6; i++) setup_m[i] = {$urandom, $urandom};
          setup_m[$urandom_range(0, 5)] = {32'h8000_0000, 32'h7FFF_FFFF};
          setup_box = {$urandom, $urandom};
          fwd = $urandom;
        end
        3: begin
          setup_box = 64'hFFFF_FFFF_FFFF_FFFF;
          fwd = 32'h0;
        end
        4: begin
          // tilted depth row with an offset
          setup_m[4] = {32'(int'($urandom_range(0, 16384)) - 8192),
                        32'(ONE_M + int'($urandom_range(0, 8192)) - 4096)};
          setup_m[5] = {32'(int'($urandom_range(0, 4 * ONE_M)) - 2 * ONE_M),
                        32'(int'($urandom_range(0, 16384)) - 8192)};
          fwd = $urandom;
        end
        5: begin
          setup_box = {$urandom, $urandom};
          fwd = 32'h7FFF_FFFF;
        end
        6: begin
          // depth falls to zero 40 m out and goes negative beyond
          setup_m[4] = {32'h0, 32'(-ONE_M)};
          setup_m[5] = {32'(40 * ONE_M), 32'h0};
        end
        7: begin
          for (int i = 0; i < 6; i++) setup_m[i] = 64'h0;
          setup_box = 64'h0;
        end
        default: ;
      endcase
      load_setup(fwd);
      run_phase((ph == 5) ? 60 : 170, (ph % 3 == 0) ? 1 : ((ph % 3 == 1) ? 2 : 0), 1'b1);
    end

    // Closing cloud, back to back
    stage_camera(700, 621 * ONE_M, 12288000, ONE_M, 32'h0);
    setup_box = {16'd30000, 16'd30000, 16'd32768, 16'd32768};
    load_setup(lpfc_pkg::FWD_RESET);
    enqueue_point(pt_of(10 * ONE_M, 0, 0, 1'b1));
    run_phase(30, 0, 1'b0);

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
